// ===== sv/sle_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sle_pkg
// Shared constants, codes and controller/datapath interface types for the
// serial line editor.
// ----------------------------------------------------------------------------
package sle_pkg;

   localparam int LINE_BYTES_DEF = 20;
   localparam int POOL_SIZE_DEF  = 2;

   localparam logic [7:0] KEY_DROP      = 8'h1A;
   localparam logic [7:0] KEY_NEWLINE   = 8'h0A;
   localparam logic [7:0] KEY_BACKSPACE = 8'h08;
   localparam logic [7:0] ALARM_CHAR    = 8'h21;

   localparam logic [1:0] KIND_ECHO    = 2'd0;
   localparam logic [1:0] KIND_ALARM   = 2'd1;
   localparam logic [1:0] KIND_DATA    = 2'd2;
   localparam logic [1:0] KIND_DROPPED = 2'd3;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EVAL,
      S_ALARM,
      S_DROP_LAST,
      S_DROP_FIRST,
      S_ECHO,
      S_PREFETCH,
      S_BURST
   } state_type;

   typedef enum logic [1:0] {
      OUT_ALARM,
      OUT_DROP,
      OUT_ECHO,
      OUT_DATA
   } out_sel_type;

   typedef struct packed {
      logic        load;
      logic        commit;
      logic        prefetch;
      logic        advance;
      out_sel_type out_sel;
      logic        last;
   } sle_cmd_type;

   typedef struct packed {
      logic release_req;
      logic alarm;
      logic term;
      logic term_empty;
      logic bs;
      logic bs_nonempty;
      logic full;
      logic burst_end;
   } sle_status_type;

endpackage
`default_nettype wire

// ===== sv/sle_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sle_ctrl
// Sequencer: takes one transaction, has the datapath commit it, then walks
// the result transactions it causes.
// ----------------------------------------------------------------------------
module sle_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_tvalid,
   output logic                         req_tready,
   output logic                         rsp_tvalid,
   input  wire logic                    rsp_tready,
   input  wire sle_pkg::sle_status_type status,
   output sle_pkg::sle_cmd_type         cmd
);
   import sle_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      req_tready   = 1'b0;
      rsp_tvalid   = 1'b0;
      cmd.load     = 1'b0;
      cmd.commit   = 1'b0;
      cmd.prefetch = 1'b0;
      cmd.advance  = 1'b0;
      cmd.out_sel  = OUT_ECHO;
      cmd.last     = 1'b1;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
            if (req_tvalid) begin
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            cmd.commit = 1'b1;
            if (status.release_req) begin
               state_in = S_IDLE;
            end else if (status.alarm) begin
               state_in = S_ALARM;
            end else if (status.term) begin
               state_in = status.term_empty ? S_DROP_LAST : S_PREFETCH;
            end else if (status.bs) begin
               state_in = status.bs_nonempty ? S_ECHO : S_IDLE;
            end else begin
               state_in = status.full ? S_DROP_FIRST : S_ECHO;
            end
         end
         S_ALARM: begin
            rsp_tvalid  = 1'b1;
            cmd.out_sel = OUT_ALARM;
            if (rsp_tready) begin
               state_in = S_IDLE;
            end
         end
         S_DROP_LAST: begin
            rsp_tvalid  = 1'b1;
            cmd.out_sel = OUT_DROP;
            if (rsp_tready) begin
               state_in = S_IDLE;
            end
         end
         S_DROP_FIRST: begin
            rsp_tvalid  = 1'b1;
            cmd.out_sel = OUT_DROP;
            cmd.last    = 1'b0;
            if (rsp_tready) begin
               state_in = S_ECHO;
            end
         end
         S_ECHO: begin
            rsp_tvalid  = 1'b1;
            cmd.out_sel = OUT_ECHO;
            if (rsp_tready) begin
               state_in = S_IDLE;
            end
         end
         S_PREFETCH: begin
            cmd.prefetch = 1'b1;
            state_in     = S_BURST;
         end
         S_BURST: begin
            rsp_tvalid  = 1'b1;
            cmd.out_sel = OUT_DATA;
            cmd.last    = status.burst_end;
            if (rsp_tready) begin
               if (status.burst_end) begin
                  state_in = S_IDLE;
               end else begin
                  cmd.advance = 1'b1;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire

// ===== sv/sle_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sle_dp
// Datapath: captured transaction, line store, line count, buffer pool
// accounting and result field selection.
// ----------------------------------------------------------------------------
module sle_dp #(
   parameter int LINE_BYTES = sle_pkg::LINE_BYTES_DEF,
   parameter int POOL_SIZE  = sle_pkg::POOL_SIZE_DEF
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_command,
   input  wire logic [7:0]              req_rx_byte,
   input  wire sle_pkg::sle_cmd_type    cmd,
   output sle_pkg::sle_status_type      status,
   output logic [1:0]                   rsp_kind,
   output logic [7:0]                   rsp_data_byte,
   output logic [4:0]                   rsp_line_length
);
   import sle_pkg::*;

   localparam int DEPTH = LINE_BYTES - 1;
   localparam int AW    = $clog2(DEPTH);
   localparam int CW    = $clog2(LINE_BYTES);
   localparam int FW    = $clog2(POOL_SIZE + 1);
   localparam int EXTW  = CW + 5;

   logic [7:0]    line_mem [DEPTH];
   logic [7:0]    rd_data_ff;
   logic [AW-1:0] rd_addr;
   logic          rd_en;
   logic          wr_en;

   logic          command_ff;
   logic [7:0]    rx_ff;
   logic [CW-1:0] count_ff, count_in;
   logic          holding_ff, holding_in;
   logic [FW-1:0] free_ff, free_in;
   logic [CW-1:0] len_ff, len_in;
   logic [AW-1:0] idx_ff, idx_in;

   logic [CW-1:0]   eff_count;
   logic [EXTW-1:0] len_ext;

   assign eff_count = holding_ff ? count_ff : '0;
   assign len_ext   = EXTW'(len_ff);

   always_comb begin
      status.release_req = command_ff;
      status.alarm       = !holding_ff && (free_ff == '0);
      status.term        = (rx_ff == KEY_DROP) || (rx_ff == KEY_NEWLINE);
      status.term_empty  = (rx_ff == KEY_DROP) || (eff_count == '0);
      status.bs          = (rx_ff == KEY_BACKSPACE);
      status.bs_nonempty = (eff_count != '0);
      status.full        = (eff_count >= CW'(DEPTH));
      status.burst_end   = ((CW'(idx_ff) + CW'(1)) == len_ff);
   end

   always_comb begin
      count_in   = count_ff;
      holding_in = holding_ff;
      free_in    = free_ff;
      len_in     = len_ff;
      wr_en      = 1'b0;
      if (cmd.commit) begin
         if (command_ff) begin
            if (free_ff < FW'(POOL_SIZE)) begin
               free_in = free_ff + FW'(1);
            end
         end else if (!status.alarm) begin
            if (!holding_ff) begin
               free_in = free_ff - FW'(1);
            end
            holding_in = 1'b1;
            if (status.term) begin
               len_in     = (rx_ff == KEY_DROP) ? '0 : eff_count;
               holding_in = 1'b0;
               count_in   = '0;
            end else if (status.bs) begin
               count_in = eff_count - CW'(status.bs_nonempty);
            end else if (status.full) begin
               holding_in = 1'b0;
               count_in   = '0;
            end else begin
               wr_en    = 1'b1;
               count_in = eff_count + CW'(1);
            end
         end
      end
   end

   always_comb begin
      idx_in  = idx_ff;
      rd_en   = 1'b0;
      rd_addr = idx_ff;
      if (cmd.prefetch) begin
         idx_in  = '0;
         rd_en   = 1'b1;
         rd_addr = '0;
      end else if (cmd.advance) begin
         idx_in  = idx_ff + AW'(1);
         rd_en   = 1'b1;
         rd_addr = idx_ff + AW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         holding_ff <= 1'b0;
         free_ff    <= FW'(POOL_SIZE);
      end else begin
         count_ff   <= count_in;
         holding_ff <= holding_in;
         free_ff    <= free_in;
      end
   end

   always_ff @(posedge clock) begin
      len_ff <= len_in;
      idx_ff <= idx_in;
      if (cmd.load) begin
         command_ff <= req_command;
         rx_ff      <= req_rx_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         line_mem[eff_count[AW-1:0]] <= rx_ff;
      end
      if (rd_en) begin
         rd_data_ff <= line_mem[rd_addr];
      end
   end

   always_comb begin
      unique case (cmd.out_sel)
         OUT_ALARM: begin
            rsp_kind        = KIND_ALARM;
            rsp_data_byte   = ALARM_CHAR;
            rsp_line_length = '0;
         end
         OUT_DROP: begin
            rsp_kind        = KIND_DROPPED;
            rsp_data_byte   = '0;
            rsp_line_length = '0;
         end
         OUT_ECHO: begin
            rsp_kind        = KIND_ECHO;
            rsp_data_byte   = rx_ff;
            rsp_line_length = '0;
         end
         OUT_DATA: begin
            rsp_kind        = KIND_DATA;
            rsp_data_byte   = rd_data_ff;
            rsp_line_length = len_ext[4:0];
         end
         default: begin
            rsp_kind        = KIND_ECHO;
            rsp_data_byte   = rx_ff;
            rsp_line_length = '0;
         end
      endcase
   end

endmodule
`default_nettype wire

// ===== sv/serial_line_editor.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// serial_line_editor
// Line discipline with backspace over a small pool of line buffers.
// ----------------------------------------------------------------------------
// Takes one transaction at a time. A transaction is accepted in one cycle and
// evaluated in the next; a release command or a silent backspace then ends
// it. An echo, alarm or dropped-line result follows one per cycle while
// rsp_tready is high; an overflowing byte gives a dropped-line result, then
// its echo. Handing on a stored line uses the line store's single registered
// read port: a prefetch state fetches the first byte, and each further byte
// is fetched in the cycle in which the byte before it is taken.
module serial_line_editor #(
   parameter int LINE_BYTES = sle_pkg::LINE_BYTES_DEF,
   parameter int POOL_SIZE  = sle_pkg::POOL_SIZE_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] rx_byte
   input  wire logic        req_tuser,   // [0] command
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,   // [7:0] data_byte, [12:8] line_length
   output logic [1:0]       rsp_tuser,   // [1:0] kind
   output logic             rsp_tlast
);
   import sle_pkg::*;

   sle_cmd_type    cmd;
   sle_status_type status;
   logic [7:0]     data_byte;
   logic [4:0]     line_length;

   sle_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   sle_dp #(
      .LINE_BYTES (LINE_BYTES),
      .POOL_SIZE  (POOL_SIZE)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .req_command     (req_tuser),
      .req_rx_byte     (req_tdata),
      .cmd             (cmd),
      .status          (status),
      .rsp_kind        (rsp_tuser),
      .rsp_data_byte   (data_byte),
      .rsp_line_length (line_length)
   );

   assign rsp_tdata = {3'b000, line_length, data_byte};
   assign rsp_tlast = cmd.last;

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !rsp_tvalid)
      else $error("input taken while a result is pending");

   a_data_has_length: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser == KIND_DATA)) |-> (rsp_tdata[12:8] != 5'd0))
      else $error("line data transaction with zero length");

   a_alarm_alone: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser == KIND_ALARM)) |-> rsp_tlast)
      else $error("alarm transaction not marked last");

   a_eval_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("second input taken before evaluation");

endmodule
`default_nettype wire
